// File: sv/cpd_pkg.sv
// Package for the command packet deframer.
// Holds the status codes and the result record shared by all modules.
// No dependencies.
package cpd_pkg;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM   = 2'd1;
    localparam logic [1:0] STATUS_BAD_START = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  command_code;
        logic [7:0]  target_index;
        logic [31:0] payload_value;
        logic [7:0]  computed_sum;
    } cpd_result_t;

endpackage

// File: sv/cpd_ifs.sv
// Valid/ready channel interfaces of the command packet deframer.
// cpd_in_if moves received bytes, cpd_out_if moves result items.
// No dependencies.
interface cpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cpd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  command_code;
    logic [7:0]  target_index;
    logic [31:0] payload_value;
    logic [7:0]  computed_sum;

    modport source (output valid, output status, output command_code,
                    output target_index, output payload_value,
                    output computed_sum, input ready);
    modport sink   (input valid, input status, input command_code,
                    input target_index, input payload_value,
                    input computed_sum, output ready);
endinterface

// File: sv/cpd_parser.sv
// Byte-level packet parser: phase, running sum and held packet fields.
// Produces at most one result per accepted byte. Depends on cpd_pkg.
module cpd_parser
    import cpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  start_byte,
    output logic        res_valid,
    output cpd_result_t res
);

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_CMD   = 3'd1;
    localparam logic [2:0] PH_TGT   = 3'd2;
    localparam logic [2:0] PH_DATA0 = 3'd3;
    localparam logic [2:0] PH_DATA1 = 3'd4;
    localparam logic [2:0] PH_DATA2 = 3'd5;
    localparam logic [2:0] PH_DATA3 = 3'd6;
    localparam logic [2:0] PH_CHECK = 3'd7;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  tgt_reg, tgt_next;
    logic [31:0] value_reg, value_next;

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        cmd_next   = cmd_reg;
        tgt_next   = tgt_reg;
        value_next = value_reg;
        res_valid  = 1'b0;
        res        = '0;
        res.status = STATUS_BAD_START;

        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == start_byte)
                    begin
                        sum_next   = rx_byte;
                        phase_next = PH_CMD;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                    end
                end
                PH_CHECK:
                begin
                    res_valid         = 1'b1;
                    res.status        = (rx_byte == sum_reg) ? STATUS_OK : STATUS_BAD_SUM;
                    res.command_code  = cmd_reg;
                    res.target_index  = tgt_reg;
                    res.payload_value = value_reg;
                    res.computed_sum  = sum_reg;
                    phase_next        = PH_HUNT;
                    sum_next          = 8'd0;
                end
                default:
                begin
                    case (phase_reg)
                        PH_CMD:   cmd_next           = rx_byte;
                        PH_TGT:   tgt_next           = rx_byte;
                        PH_DATA0: value_next[7:0]    = rx_byte;
                        PH_DATA1: value_next[15:8]   = rx_byte;
                        PH_DATA2: value_next[23:16]  = rx_byte;
                        PH_DATA3: value_next[31:24]  = rx_byte;
                        default:  cmd_next           = cmd_reg;
                    endcase
                    sum_next   = sum_reg + rx_byte;
                    phase_next = phase_reg + 3'd1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            sum_reg   <= 8'd0;
            cmd_reg   <= 8'd0;
            tgt_reg   <= 8'd0;
            value_reg <= 32'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            cmd_reg   <= cmd_next;
            tgt_reg   <= tgt_next;
            value_reg <= value_next;
        end
    end

endmodule

// File: sv/cpd_result_buf.sv
// Two-entry result buffer between the parser and the output channel.
// Ready toward the input side comes from the fill count only. Depends on cpd_pkg.
module cpd_result_buf
    import cpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  cpd_result_t push_data,
    output logic        has_room,
    output logic        out_valid,
    input  logic        out_ready,
    output cpd_result_t out_data
);

    logic [1:0]  count_reg, count_next;
    cpd_result_t head_reg, head_next;
    cpd_result_t skid_reg, skid_next;
    logic        pop;

    assign pop       = out_valid && out_ready;
    assign has_room  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = head_reg;

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        skid_next  = skid_reg;
        case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                    head_next = push_data;
                else
                    skid_next = push_data;
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                head_next  = skid_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    head_next = push_data;
                end
                else
                begin
                    head_next = skid_reg;
                    skid_next = push_data;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

// File: sv/command_packet_deframer_unit.sv
// Top level of the command packet deframer.
// Ties the start-byte register, cpd_parser and cpd_result_buf to the channels.
// Depends on cpd_pkg, cpd_ifs, cpd_parser and cpd_result_buf.

// The deframer takes one received byte per item, one item per clock cycle,
// and hunts for the configured start byte. After it, a command byte, a target
// byte, four value bytes (least significant first) and a checksum byte follow.
// The checksum byte is compared with the 8-bit wrapped sum of all bytes from
// the start byte on; the packet comes out with status valid or checksum
// mismatch. A byte other than the start byte while hunting gives a bad-start
// item with all other fields zero. A start byte inside a packet is ordinary
// data. Each byte is parsed in the cycle it is accepted and its result lands
// in a two-entry output buffer in the next cycle; input ready drops only while
// both buffer entries wait to be taken, so a byte is accepted every cycle as
// long as results drain. Write start_byte only while idle; it applies from
// the next byte on.
module command_packet_deframer_unit
    import cpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    cpd_in_if.sink     in_ch,
    cpd_out_if.source  out_ch
);

    logic [7:0]  start_byte_reg;
    logic        accept;
    logic        res_valid;
    logic        has_room;
    cpd_result_t res;
    cpd_result_t out_data;

    // Hold the start byte until the next configuration write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_byte_reg <= 8'd0;
        else if (cfg_wr_en)
            start_byte_reg <= cfg_wr_data;
    end

    // Accept a byte whenever the buffer can take a possible result.
    assign in_ch.ready = has_room;
    assign accept      = in_ch.valid && has_room;

    cpd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (in_ch.rx_byte),
        .start_byte (start_byte_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    cpd_result_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .has_room  (has_room),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

    // Unpack the buffered result onto the output channel.
    assign out_ch.status        = out_data.status;
    assign out_ch.command_code  = out_data.command_code;
    assign out_ch.target_index  = out_data.target_index;
    assign out_ch.payload_value = out_data.payload_value;
    assign out_ch.computed_sum  = out_data.computed_sum;

endmodule

// File: sv/cpd_checker.sv
// Port-level checker for command_packet_deframer_unit and its bind statement.
// Depends on cpd_pkg and the top level.
module cpd_checker
    import cpd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [7:0]  command_code,
    input logic [7:0]  target_index,
    input logic [31:0] payload_value,
    input logic [7:0]  computed_sum
);

    // Hold a result item until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    // Drop input ready only while a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !$past(out_valid && out_ready) || out_valid)
        else $error("input stalled with no pending result");

    // Never emit an undefined status code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_BAD_SUM ||
                       status == STATUS_BAD_START))
        else $error("undefined status code");

    // Clear all packet fields on a bad-start item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_BAD_START |->
            command_code == 8'd0 && target_index == 8'd0 &&
            payload_value == 32'd0 && computed_sum == 8'd0)
        else $error("bad-start item carries packet fields");

endmodule

bind command_packet_deframer_unit cpd_checker u_cpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .status        (out_ch.status),
    .command_code  (out_ch.command_code),
    .target_index  (out_ch.target_index),
    .payload_value (out_ch.payload_value),
    .computed_sum  (out_ch.computed_sum)
);

// File: tb/sv/tb.sv
// Self-checking bench for command_packet_deframer_unit.
// Runs a directed table of bytes and packets, then about a thousand random bytes.
// Depends on cpd_pkg, cpd_ifs and the deframer RTL; reads no files.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cpd_pkg::*;

    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 500;
    localparam int MAX_PRINTED     = 40;

    // Parser position, mirrors the byte layout of one packet.
    typedef enum logic [2:0] {
        PH_HUNT, PH_CMD, PH_TGT, PH_VAL0, PH_VAL1, PH_VAL2, PH_VAL3, PH_SUM
    } parse_phase_t;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  data;
        logic        has_lit;
        cpd_result_t lit;
    } stim_row_t;

    localparam cpd_result_t NO_RESULT = '0;
    localparam cpd_result_t BAD_START_ITEM =
        '{STATUS_BAD_START, 8'h00, 8'h00, 32'h0000_0000, 8'h00};

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    cpd_in_if  in_ch ();
    cpd_out_if out_ch ();

    command_packet_deframer_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // Directed table. Rows with a typed-in result are ones that can be read
    // straight off the packet format; all other rows go through the predictor.
    stim_row_t script [0:27] = '{
        // start byte is 0 after reset: a stray byte reports bad start
        '{ROW_BYTE, 8'hFF, 1'b1, BAD_START_ITEM},
        // all-ones packet: sum of 0 + six 0xFF bytes wraps to 0xFA
        '{ROW_BYTE, 8'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'hFF, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'hFF, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'hFF, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'hFF, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'hFF, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'hFF, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'hFA, 1'b1,
          '{STATUS_OK, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFA}},
        // move the start byte to the other extreme
        '{ROW_CFG,  8'hFF, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'h00, 1'b1, BAD_START_ITEM},
        // start byte reused as target is plain data; checksum is wrong
        '{ROW_BYTE, 8'hFF, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'hFF, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'h00, 1'b1,
          '{STATUS_BAD_SUM, 8'h00, 8'hFF, 32'h0000_0000, 8'hFE}},
        // mixed-value packet, byte order of the value checked by the predictor
        '{ROW_CFG,  8'h5A, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'h5A, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'h01, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'h80, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'h78, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'h56, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'h34, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'h12, 1'b0, NO_RESULT},
        '{ROW_BYTE, 8'h00, 1'b0, NO_RESULT}
    };

    // Predictor state, reset values as after rst_n.
    parse_phase_t pp_phase = PH_HUNT;
    logic [7:0]   pp_start = 8'h00;
    logic [7:0]   pp_sum   = 8'h00;
    logic [7:0]   pp_cmd   = 8'h00;
    logic [7:0]   pp_tgt   = 8'h00;
    logic [31:0]  pp_val   = 32'h0;

    cpd_result_t packets_due [$];
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    bit          steady       = 1'b0;

    // Advance the predictor by one byte; return 1 when the byte yields an item.
    function automatic bit parse_byte(input logic [7:0] b, output cpd_result_t r);
        r = NO_RESULT;
        case (pp_phase)
            PH_HUNT:
            begin
                if (b == pp_start)
                begin
                    pp_sum   = b;
                    pp_phase = PH_CMD;
                    return 1'b0;
                end
                r.status = STATUS_BAD_START;
                return 1'b1;
            end
            PH_SUM:
            begin
                r.status        = (b == pp_sum) ? STATUS_OK : STATUS_BAD_SUM;
                r.command_code  = pp_cmd;
                r.target_index  = pp_tgt;
                r.payload_value = pp_val;
                r.computed_sum  = pp_sum;
                pp_phase        = PH_HUNT;
                pp_sum          = 8'h00;
                return 1'b1;
            end
            PH_CMD: pp_cmd = b;
            PH_TGT: pp_tgt = b;
            default: pp_val[8 * (int'(pp_phase) - int'(PH_VAL0)) +: 8] = b;
        endcase
        pp_sum   = pp_sum + b;
        pp_phase = parse_phase_t'(pp_phase + 3'd1);
        return 1'b0;
    endfunction

    // No idle gap in steady stretches, otherwise a random idle gap.
    function automatic int pick_gap();
        return steady ? 0 : int'($urandom_range(0, 7));
    endfunction

    // Lean toward the extremes so every bit toggles early.
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t ns mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Offer one byte after a random gap, hold it until taken, then predict.
    // Without a gap, valid stays high, so valid is never dropped and raised
    // in the same step.
    task automatic send_byte(input logic [7:0] b, input logic has_lit = 1'b0,
                             input cpd_result_t lit = NO_RESULT);
        int          gap;
        cpd_result_t r;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (parse_byte(b, r))
            packets_due.push_back(has_lit ? lit : r);
    endtask

    // Change the start byte only once the deframer has drained and settled.
    task automatic write_start(input logic [7:0] v);
        in_ch.valid <= 1'b0;
        while (packets_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        pp_start = v;
        cfg_wr_en <= 1'b0;
    endtask

    // Start byte, body bytes, then a checksum that is right three times in
    // four. Without a checksum the packet is cut short and the bytes that
    // follow finish it.
    task automatic send_packet(input logic [7:0] start, input int body_len,
                               input bit with_sum, inout int sent);
        logic [7:0] b;
        logic [7:0] sum;
        sum = start;
        send_byte(start);
        for (int k = 0; k < body_len; k++)
        begin
            b   = rand_byte();
            sum = sum + b;
            send_byte(b);
        end
        if (with_sum)
        begin
            if ($urandom_range(0, 3) == 0)
                sum = sum ^ (8'h01 << $urandom_range(0, 7));
            send_byte(sum);
        end
        sent += 1 + body_len + int'(with_sum);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: stall a random number of cycles, then hold ready until an
    // item moves. Without a stall, ready stays high across back-to-back items.
    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        forever
        begin
            stall = pick_gap();
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    // Compare every taken item with the oldest prediction.
    always @(posedge clk)
    begin
        cpd_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (packets_due.size() == 0)
                report_mismatch($sformatf("unexpected item status %0d sum %0h",
                                          out_ch.status, out_ch.computed_sum));
            else
            begin
                want = packets_due.pop_front();
                check_field("status", 32'(out_ch.status), 32'(want.status));
                check_field("command_code", 32'(out_ch.command_code),
                            32'(want.command_code));
                check_field("target_index", 32'(out_ch.target_index),
                            32'(want.target_index));
                check_field("payload_value", out_ch.payload_value, want.payload_value);
                check_field("computed_sum", 32'(out_ch.computed_sum),
                            32'(want.computed_sum));
            end
        end
    end

    // Drop the run if no item moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d items outstanding",
                     quiet_cycles, packets_due.size());
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [7:0] start;
        int         sent;
        int         pick;

        in_ch.valid   <= 1'b0;
        in_ch.rx_byte <= 8'h00;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= 8'h00;
        rst_n         <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table.
        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
                write_start(script[i].data);
            else
                send_byte(script[i].data, script[i].has_lit, script[i].lit);
        end

        // Random phases: extremes of the start byte first, then random ones.
        // Mostly whole packets with random content; the rest is stray bytes
        // and packets cut short, which throw the framing off on purpose.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0: start = 8'h00;
                1: start = 8'hFF;
                default: start = 8'($urandom_range(0, 255));
            endcase
            write_start(start);
            steady = (p % 3 == 2);
            sent   = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    send_packet(start, 6, 1'b1, sent);
                else if (pick < 9)
                begin
                    send_byte(rand_byte());
                    sent++;
                end
                else
                    send_packet(start, $urandom_range(0, 5), 1'b0, sent);
            end
        end

        // Drain, give the buffer time to show any extra item, then judge.
        steady = 1'b0;
        in_ch.valid <= 1'b0;
        while (packets_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
